// ===== rtl/core/global_to_local_id_table_unit_defines.svh =====
// Assertion macros shared by the id interning table RTL.
// Included by the top level; no other dependencies.
`ifndef GLOBAL_TO_LOCAL_ID_TABLE_UNIT_DEFINES_SVH
`define GLOBAL_TO_LOCAL_ID_TABLE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define GTL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define GTL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/gtl_pkg.sv =====
// Shared types and constants for the id interning table.
// Field layout of the request and response beats, action and status codes.
package gtl_pkg;

   localparam int ACT_W  = 2;
   localparam int GID_W  = 32;
   localparam int LIDX_W = 10;
   localparam int REQ_W  = 48;

   localparam int REQ_ACT_LSB  = 0;
   localparam int REQ_GID_LSB  = REQ_ACT_LSB + ACT_W;
   localparam int REQ_LIDX_LSB = REQ_GID_LSB + GID_W;

   localparam int STAT_W = 3;
   localparam int LRES_W = 10;
   localparam int GRES_W = 32;
   localparam int ECNT_W = 11;
   localparam int RSP_W  = STAT_W + LRES_W + GRES_W + ECNT_W;

   // Odd multiplier for the home slot hash.
   localparam logic [31:0] HASH_MULT = 32'h9E3779B1;

   typedef enum logic [ACT_W-1:0] {
      ACT_ADD   = 2'd0,
      ACT_READ  = 2'd1,
      ACT_CLEAR = 2'd2
   } action_type;

   typedef enum logic [STAT_W-1:0] {
      ST_FOUND    = 3'd0,
      ST_INSERTED = 3'd1,
      ST_FULL     = 3'd2,
      ST_RANGE    = 3'd3,
      ST_CLEARED  = 3'd4
   } status_type;

endpackage

// ===== rtl/core/global_to_local_id_table_unit.sv =====
// Id interning table: maps sparse global ids to dense local indices.
// Depends on gtl_pkg and global_to_local_id_table_unit_defines.svh.
//
// Usage:
//   The req channel carries one item per beat: an action (add or find, read
//   reverse entry, clear), a global id and a local index. The rsp channel
//   returns exactly one beat per item with status, local index, global id
//   and the entry count after the item.
//   Items are handled one at a time; req_tready is high only while the
//   control is idle. An add passes through the hash, probe, check and
//   response states and stays in check for every extra probe of the
//   open-addressed slot memory (linear probing); the probe loop runs on
//   the slot memory read port. The control is idle again in the same cycle
//   that rsp_tvalid rises, so the next item can be taken in that cycle.
//   A read does one reverse memory read. A clear sweeps the slot memory,
//   one entry a cycle, and then responds.
//   After reset the block runs the same sweep over every slot before it
//   takes the first item. The response sits in an output register: when the
//   receiver stalls, the next item is still accepted and worked on, and its
//   result waits in the control until the output register is taken.
`include "global_to_local_id_table_unit_defines.svh"

module global_to_local_id_table_unit #(
   parameter int CAPACITY = 1024,
   parameter int SLOTS    = 2048,
   parameter int ID_BITS  = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // action[1:0], gid[33:2], local_index[43:34], zero fill [47:44]
   input  logic [gtl_pkg::REQ_W-1:0] req_tdata,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // status[2:0], local_result[12:3], global_result[44:13], entry_count[55:45]
   output logic [gtl_pkg::RSP_W-1:0] rsp_tdata
);
   import gtl_pkg::*;

   localparam int KEY_W   = (ID_BITS < GID_W) ? ID_BITS : GID_W;
   localparam int LOC_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W   = $clog2(CAPACITY + 1);
   localparam int SLOT_W  = $clog2(SLOTS);
   localparam int SLOT_DW = 1 + LOC_W + KEY_W;
   localparam int CMP_W   = (CNT_W > LIDX_W) ? CNT_W : LIDX_W;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_HASH,
      S_PROBE,
      S_CHECK,
      S_REV,
      S_RESP
   } state_type;

   // Slot entry: {valid, local index, key}. Reverse memory holds keys.
   logic [SLOT_DW-1:0] slot_mem [SLOTS];
   logic [KEY_W-1:0]   rev_mem  [CAPACITY];

   state_type          state_ff, state_in;
   logic [SLOT_W-1:0]  clr_addr_ff, clr_addr_in;
   logic               clr_ack_ff, clr_ack_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]   rsp_tdata_ff, rsp_tdata_in;

   logic [KEY_W-1:0]   key_ff, key_in;
   logic [31:0]        hmul_ff, hmul_in;
   logic [SLOT_W-1:0]  probe_ff, probe_in;
   logic [SLOT_W-1:0]  tries_ff, tries_in;
   logic               in_range_ff, in_range_in;
   status_type         res_status_ff, res_status_in;
   logic [LOC_W-1:0]   res_local_ff, res_local_in;
   logic [KEY_W-1:0]   res_global_ff, res_global_in;

   logic [SLOT_DW-1:0] slot_rd_ff;
   logic [KEY_W-1:0]   rev_rd_ff;
   logic               slot_we;
   logic [SLOT_W-1:0]  slot_wa;
   logic [SLOT_DW-1:0] slot_wd;
   logic [SLOT_W-1:0]  slot_rd_addr;
   logic               rev_we;
   logic [LOC_W-1:0]   rev_wa;
   logic [LOC_W-1:0]   rev_rd_addr;

   logic [ACT_W-1:0]   req_action;
   logic [GID_W-1:0]   req_gid;
   logic [LIDX_W-1:0]  req_local_index;
   logic               req_fire;
   logic [31:0]        hmix;
   logic [SLOT_W-1:0]  home_slot;
   logic [SLOT_W-1:0]  probe_nxt;
   logic               ent_valid;
   logic [LOC_W-1:0]   ent_local;
   logic [KEY_W-1:0]   ent_key;
   logic               ins_now;
   logic               clr_last;

   assign req_action      = req_tdata[REQ_ACT_LSB +: ACT_W];
   assign req_gid         = req_tdata[REQ_GID_LSB +: GID_W];
   assign req_local_index = req_tdata[REQ_LIDX_LSB +: LIDX_W];

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // Multiply-high maps the mixed hash onto any slot count.
   assign hmix      = hmul_ff ^ (hmul_ff >> 16);
   assign home_slot = SLOT_W'((64'(hmix) * 64'(SLOTS)) >> 32);
   assign probe_nxt = (probe_ff == SLOT_W'(SLOTS - 1)) ? '0 : probe_ff + 1'b1;

   assign ent_valid = slot_rd_ff[SLOT_DW-1];
   assign ent_local = slot_rd_ff[KEY_W +: LOC_W];
   assign ent_key   = slot_rd_ff[KEY_W-1:0];
   assign clr_last  = (clr_addr_ff == SLOT_W'(SLOTS - 1));

   assign rev_wa      = LOC_W'(count_ff);
   assign rev_rd_addr = LOC_W'(req_local_index);

   always_comb begin
      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      clr_ack_in    = clr_ack_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      key_in        = key_ff;
      hmul_in       = hmul_ff;
      probe_in      = probe_ff;
      tries_in      = tries_ff;
      in_range_in   = in_range_ff;
      res_status_in = res_status_ff;
      res_local_in  = res_local_ff;
      res_global_in = res_global_ff;
      slot_we       = 1'b0;
      slot_wa       = probe_ff;
      slot_wd       = {1'b1, LOC_W'(count_ff), key_ff};
      slot_rd_addr  = probe_ff;
      rev_we        = 1'b0;
      ins_now       = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            slot_we     = 1'b1;
            slot_wa     = clr_addr_ff;
            slot_wd     = '0;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_last) begin
               count_in = '0;
               if (clr_ack_ff) begin
                  res_status_in = ST_CLEARED;
                  res_local_in  = '0;
                  res_global_in = '0;
                  state_in      = S_RESP;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               key_in        = KEY_W'(req_gid);
               hmul_in       = 32'(32'(KEY_W'(req_gid)) * HASH_MULT);
               in_range_in   = CMP_W'(req_local_index) < CMP_W'(count_ff);
               res_local_in  = '0;
               res_global_in = '0;
               case (req_action)
                  ACT_ADD:   state_in = S_HASH;
                  ACT_READ:  state_in = S_REV;
                  ACT_CLEAR: begin
                     clr_addr_in = '0;
                     clr_ack_in  = 1'b1;
                     state_in    = S_CLEAR;
                  end
                  default: begin
                     res_status_in = ST_RANGE;
                     state_in      = S_RESP;
                  end
               endcase
            end
         end
         S_HASH: begin
            probe_in = home_slot;
            tries_in = '0;
            state_in = S_PROBE;
         end
         S_PROBE: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (!ent_valid) begin
               if (count_ff >= CNT_W'(CAPACITY)) begin
                  res_status_in = ST_FULL;
               end else begin
                  ins_now       = 1'b1;
                  slot_we       = 1'b1;
                  rev_we        = 1'b1;
                  count_in      = count_ff + 1'b1;
                  res_status_in = ST_INSERTED;
                  res_local_in  = LOC_W'(count_ff);
               end
               state_in = S_RESP;
            end else if (ent_key == key_ff) begin
               res_status_in = ST_FOUND;
               res_local_in  = ent_local;
               state_in      = S_RESP;
            end else if (tries_ff == SLOT_W'(SLOTS - 1)) begin
               // Every slot was probed and none is free.
               res_status_in = ST_FULL;
               state_in      = S_RESP;
            end else begin
               probe_in     = probe_nxt;
               tries_in     = tries_ff + 1'b1;
               slot_rd_addr = probe_nxt;
            end
         end
         S_REV: begin
            if (in_range_ff) begin
               res_status_in = ST_FOUND;
               res_global_in = rev_rd_ff;
            end else begin
               res_status_in = ST_RANGE;
            end
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_tdata_in = {ECNT_W'(count_ff), GRES_W'(res_global_ff),
                               LRES_W'(res_local_ff), res_status_ff};
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_addr_ff  <= '0;
         clr_ack_ff   <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         clr_ack_ff   <= clr_ack_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_tdata_ff  <= rsp_tdata_in;
      key_ff        <= key_in;
      hmul_ff       <= hmul_in;
      probe_ff      <= probe_in;
      tries_ff      <= tries_in;
      in_range_ff   <= in_range_in;
      res_status_ff <= res_status_in;
      res_local_ff  <= res_local_in;
      res_global_ff <= res_global_in;
   end

   // Both memories read every cycle; the read data is registered and valid in the next cycle.
   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_mem[slot_wa] <= slot_wd;
      end
      slot_rd_ff <= slot_mem[slot_rd_addr];
      if (rev_we) begin
         rev_mem[rev_wa] <= key_ff;
      end
      rev_rd_ff <= rev_mem[rev_rd_addr];
   end

   `GTL_ASSERT_NEXT(a_one_item, clock, reset, req_fire, !req_tready, "item overlap")
   `GTL_ASSERT_NEXT(a_insert_count, clock, reset, ins_now,
                    count_ff == $past(count_ff) + 1'b1, "insert did not bump count")
   `GTL_ASSERT_NEXT(a_clear_count, clock, reset, (state_ff == S_CLEAR) && clr_last,
                    count_ff == '0, "count not zero after sweep")
   `GTL_ASSERT_NOW(a_count_cap, clock, reset, state_ff == S_CHECK,
                   count_ff <= CNT_W'(CAPACITY), "count above capacity")

endmodule
